// ----- design/assert_macros.svh -----
// Assertion macros used by the rasterizer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- design/mer_pkg.sv -----
package mer_pkg;

   // Default coordinate width of the centre and radius fields.
   localparam int COORD_BITS_DEF = 10;

   // Index of the fourth pixel of a step.
   localparam logic [1:0] PIX_LAST = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_LOAD    = 4'd1,
      OP_SNAP    = 4'd2,
      OP_LD_MUL1 = 4'd3,
      OP_LD_MUL2 = 4'd4,
      OP_LD_MUL3 = 4'd5,
      OP_LD_FIN  = 4'd6,
      OP_UPD_R1  = 4'd7,
      OP_UPD_R2  = 4'd8,
      OP_SU1     = 4'd9,
      OP_SU2     = 4'd10,
      OP_SU3     = 4'd11,
      OP_SU4     = 4'd12,
      OP_SU5     = 4'd13,
      OP_SU6     = 4'd14
   } dp_op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      dp_op_type  op;
      logic [1:0] pix_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic gx_lt_gy;
      logic sy_neg;
      logic sy_zero;
   } dp_status_type;

endpackage

// ----- design/mer_datapath.sv -----
module mer_datapath
   import mer_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  dp_cmd_type                   cmd,
   input  logic [COORD_BITS-1:0]        center_x,
   input  logic [COORD_BITS-1:0]        center_y,
   input  logic [COORD_BITS-1:0]        radius_x,
   input  logic [COORD_BITS-1:0]        radius_y,
   output dp_status_type                status,
   output logic signed [COORD_BITS+1:0] pixel_x,
   output logic signed [COORD_BITS+1:0] pixel_y
);

   localparam int CW  = COORD_BITS + 1;
   localparam int PW  = COORD_BITS + 2;
   localparam int SQW = 2 * COORD_BITS;
   localparam int MW  = 2 * COORD_BITS + 2;
   localparam int PRW = 2 * MW;
   localparam int GW  = 3 * COORD_BITS + 3;
   localparam int DW  = 4 * COORD_BITS + 5;
   localparam logic signed [DW-1:0] DEC_ONE = DW'(1);

   logic [COORD_BITS-1:0] cx_ff, cy_ff, rad_x_ff;
   logic [SQW-1:0]        rx2_ff, ry2_ff;
   logic signed [CW-1:0]  sx_ff, sy_ff, snap_x_ff, snap_y_ff;
   logic signed [GW-1:0]  gx_ff, gy_ff;
   logic signed [DW-1:0]  dec_ff, acc_ff;
   logic [MW-1:0]         t_ff;
   logic [PRW-1:0]        prod_ff;

   logic [MW-1:0]         mult_a, mult_b;
   logic [PRW-1:0]        prod_in;
   logic [MW-1:0]         x_u;
   logic signed [CW:0]    ym;
   logic [CW:0]           ym_abs;
   logic signed [GW-1:0]  rx2x2_g, ry2x2_g, gx_up, gy_dn, gy_ld;
   logic signed [DW-1:0]  gx_up_d, gy_dn_d, rx2_d, ry2_d, prod_d, q_d, rx2q_d;
   logic signed [DW-1:0]  dec_r1_lt, dec_r1_ge, dec_r2_gt, dec_r2_le;
   logic signed [DW-1:0]  dec_ld, su_sum, su_fix;
   logic                  dec_neg, dec_pos;
   logic signed [PW-1:0]  cx_p, cy_p, sx_p, sy_p;

   // Operand views of the step registers.
   assign x_u    = MW'(unsigned'(sx_ff));
   assign ym     = {sy_ff[CW-1], sy_ff} - (CW+1)'(1);
   assign ym_abs = ym[CW] ? -ym : ym;

   // Shared multiplier operand selection.
   always_comb begin
      mult_a = '0;
      mult_b = '0;
      unique case (cmd.op)
         OP_LD_MUL1: begin
            mult_a = MW'(rad_x_ff);
            mult_b = MW'(rad_x_ff);
         end
         OP_LD_MUL2: begin
            mult_a = MW'(sy_ff[COORD_BITS-1:0]);
            mult_b = MW'(sy_ff[COORD_BITS-1:0]);
         end
         OP_LD_MUL3: begin
            mult_a = MW'(rx2_ff);
            mult_b = MW'(sy_ff[COORD_BITS-1:0]);
         end
         OP_SU1: begin
            mult_a = x_u;
            mult_b = x_u;
         end
         OP_SU2: begin
            mult_a = MW'(ym_abs);
            mult_b = MW'(ym_abs);
         end
         OP_SU3: begin
            mult_a = MW'(ry2_ff);
            mult_b = t_ff;
         end
         OP_SU4: begin
            mult_a = MW'(rx2_ff);
            mult_b = t_ff;
         end
         OP_SU5: begin
            mult_a = MW'(rx2_ff);
            mult_b = MW'(ry2_ff);
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign prod_in = mult_a * mult_b;

   // Gradient updates and their extension to the decision width.
   assign rx2x2_g = GW'({rx2_ff, 1'b0});
   assign ry2x2_g = GW'({ry2_ff, 1'b0});
   assign gx_up   = gx_ff + ry2x2_g;
   assign gy_dn   = gy_ff - rx2x2_g;
   assign gy_ld   = GW'({prod_ff, 1'b0});
   assign gx_up_d = DW'(gx_up);
   assign gy_dn_d = DW'(gy_dn);
   assign rx2_d   = DW'(rx2_ff);
   assign ry2_d   = DW'(ry2_ff);
   assign prod_d  = DW'(prod_ff);
   assign q_d     = DW'(ry2_ff >> 2);
   assign rx2q_d  = DW'(rx2_ff >> 2);

   // Midpoint decision updates for both regions.
   assign dec_neg   = dec_ff[DW-1];
   assign dec_pos   = !dec_neg && (dec_ff != '0);
   assign dec_r1_lt = dec_ff + gx_up_d + ry2_d;
   assign dec_r1_ge = dec_ff + gx_up_d - gy_dn_d + ry2_d;
   assign dec_r2_gt = dec_ff + rx2_d - gy_dn_d;
   assign dec_r2_le = dec_ff + gx_up_d - gy_dn_d + rx2_d;

   // Initial decision values for region 1 and for region 2.
   assign dec_ld = ry2_d - prod_d + rx2q_d;
   assign su_sum = acc_ff - prod_d + q_d;
   assign su_fix = (su_sum[DW-1] && (ry2_ff[1:0] == 2'b01)) ? su_sum + DEC_ONE : su_sum;

   // Register updates per operation.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         OP_LOAD: begin
            cx_ff    <= center_x;
            cy_ff    <= center_y;
            rad_x_ff <= radius_x;
            sx_ff    <= '0;
            sy_ff    <= CW'(radius_y);
            gx_ff    <= '0;
         end
         OP_SNAP: begin
            snap_x_ff <= sx_ff;
            snap_y_ff <= sy_ff;
         end
         OP_LD_MUL2: begin
            rx2_ff <= prod_ff[SQW-1:0];
         end
         OP_LD_MUL3: begin
            ry2_ff <= prod_ff[SQW-1:0];
         end
         OP_LD_FIN: begin
            gy_ff  <= gy_ld;
            dec_ff <= dec_ld;
         end
         OP_UPD_R1: begin
            sx_ff <= sx_ff + CW'(1);
            gx_ff <= gx_up;
            if (dec_neg) begin
               dec_ff <= dec_r1_lt;
            end else begin
               sy_ff  <= sy_ff - CW'(1);
               gy_ff  <= gy_dn;
               dec_ff <= dec_r1_ge;
            end
         end
         OP_UPD_R2: begin
            sy_ff <= sy_ff - CW'(1);
            gy_ff <= gy_dn;
            if (dec_pos) begin
               dec_ff <= dec_r2_gt;
            end else begin
               sx_ff  <= sx_ff + CW'(1);
               gx_ff  <= gx_up;
               dec_ff <= dec_r2_le;
            end
         end
         OP_SU2: begin
            t_ff <= prod_ff[MW-1:0] + x_u;
         end
         OP_SU3: begin
            t_ff <= prod_ff[MW-1:0];
         end
         OP_SU4: begin
            acc_ff <= prod_d;
         end
         OP_SU5: begin
            acc_ff <= acc_ff + prod_d;
         end
         OP_SU6: begin
            dec_ff <= su_fix;
         end
         default: begin
         end
      endcase
   end

   // Status for the controller.
   assign status.gx_lt_gy = gx_ff < gy_ff;
   assign status.sy_neg   = sy_ff[CW-1];
   assign status.sy_zero  = (sy_ff == '0);

   // Symmetric pixel selected by the controller's pixel index.
   assign cx_p    = PW'(cx_ff);
   assign cy_p    = PW'(cy_ff);
   assign sx_p    = PW'(snap_x_ff);
   assign sy_p    = PW'(snap_y_ff);
   assign pixel_x = cmd.pix_sel[0] ? cx_p - sx_p : cx_p + sx_p;
   assign pixel_y = cmd.pix_sel[1] ? cy_p - sy_p : cy_p + sy_p;

endmodule

// ----- design/mer_ctrl.sv -----
`include "assert_macros.svh"

module mer_ctrl
   import mer_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_kind,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_last_of_step,
   output logic          rsp_figure_done,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_LD1  = 13'b0000000000010,
      ST_LD2  = 13'b0000000000100,
      ST_LD3  = 13'b0000000001000,
      ST_LD4  = 13'b0000000010000,
      ST_UPD  = 13'b0000000100000,
      ST_RES  = 13'b0000001000000,
      ST_SU1  = 13'b0000010000000,
      ST_SU2  = 13'b0000100000000,
      ST_SU3  = 13'b0001000000000,
      ST_SU4  = 13'b0010000000000,
      ST_SU5  = 13'b0100000000000,
      ST_SU6  = 13'b1000000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_R1   = 3'b010,
      PH_R2   = 3'b100
   } phase_type;

   state_type  st_ff, st_in;
   phase_type  phase_ff, phase_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       done_ff, done_in;
   logic       req_accept, rsp_accept, step_go;

   // Handshakes: intake waits for the sequencer and for the last pixel to leave.
   assign rsp_valid  = busy_ff;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (st_ff != ST_IDLE) ||
                       (busy_ff && !(rsp_accept && (idx_ff == PIX_LAST)));
   assign req_accept = req_valid && !req_stall;
   assign step_go    = req_accept && req_kind && (phase_ff != PH_IDLE);

   assign rsp_last_of_step = (idx_ff == PIX_LAST);
   assign rsp_figure_done  = (idx_ff == PIX_LAST) && done_ff;

   // Sequencer for load, update, region change and region-2 setup.
   always_comb begin
      st_in       = st_ff;
      phase_in    = phase_ff;
      cmd.op      = OP_NONE;
      cmd.pix_sel = idx_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_kind) begin
                  cmd.op   = OP_LOAD;
                  phase_in = PH_R1;
                  st_in    = ST_LD1;
               end else if (phase_ff != PH_IDLE) begin
                  cmd.op = OP_SNAP;
                  st_in  = ST_UPD;
               end
            end
         end
         ST_LD1: begin
            cmd.op = OP_LD_MUL1;
            st_in  = ST_LD2;
         end
         ST_LD2: begin
            cmd.op = OP_LD_MUL2;
            st_in  = ST_LD3;
         end
         ST_LD3: begin
            cmd.op = OP_LD_MUL3;
            st_in  = ST_LD4;
         end
         ST_LD4: begin
            cmd.op = OP_LD_FIN;
            st_in  = ST_RES;
         end
         ST_UPD: begin
            cmd.op = (phase_ff == PH_R1) ? OP_UPD_R1 : OP_UPD_R2;
            st_in  = ST_RES;
         end
         ST_RES: begin
            if ((phase_ff == PH_R1) && !status.gx_lt_gy) begin
               st_in = ST_SU1;
            end else begin
               if ((phase_ff == PH_R2) && status.sy_neg) begin
                  phase_in = PH_IDLE;
               end
               st_in = ST_IDLE;
            end
         end
         ST_SU1: begin
            cmd.op = OP_SU1;
            st_in  = ST_SU2;
         end
         ST_SU2: begin
            cmd.op = OP_SU2;
            st_in  = ST_SU3;
         end
         ST_SU3: begin
            cmd.op = OP_SU3;
            st_in  = ST_SU4;
         end
         ST_SU4: begin
            cmd.op = OP_SU4;
            st_in  = ST_SU5;
         end
         ST_SU5: begin
            cmd.op = OP_SU5;
            st_in  = ST_SU6;
         end
         ST_SU6: begin
            cmd.op   = OP_SU6;
            phase_in = PH_R2;
            st_in    = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Pixel emission: four words per step, the final flag fixed at intake.
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      done_in = done_ff;
      priority if (step_go) begin
         busy_in = 1'b1;
         idx_in  = '0;
         done_in = (phase_ff == PH_R2) && status.sy_zero;
      end else if (rsp_accept) begin
         if (idx_ff == PIX_LAST) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         phase_ff <= PH_IDLE;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
   end

   // No new item enters before the fourth pixel of a step is taken.
   `ASSERT_NOW(a_no_intake_mid_step, clock, reset, busy_ff && (idx_ff != PIX_LAST), req_stall)
   // The final pixel of a figure leaves the block with nothing left to draw.
   `ASSERT_NEXT(a_done_goes_idle, clock, reset, rsp_accept && rsp_figure_done && !req_accept, phase_ff == PH_IDLE)
   // A load starts the multiply sequence in region 1.
   `ASSERT_NEXT(a_load_starts, clock, reset, req_accept && !req_kind, (st_ff == ST_LD1) && (phase_ff == PH_R1))

endmodule

// ----- design/midpoint_ellipse_raster.sv -----
// Midpoint ellipse rasterizer.
// The req channel takes one word per item: kind 0 loads a centre and two
// semi-axes, kind 1 asks for the next raster step. A step returns four words
// on the rsp channel, the symmetric pixels (+x,+y), (-x,+y), (+x,-y), (-x,-y),
// the fourth marked last_of_step and, on the final step, figure_done.
// A step while no figure is active is accepted and returns nothing.
// The first pixel appears in the cycle after the step is accepted and
// the rest follow one per cycle while rsp_stall is low; a new step is taken
// no earlier than the fourth pixel word of the last step.
// A load holds req_stall high through states LD1, LD2, LD3, LD4 and RES,
// with LD1 to LD3 on the shared multiplier, before the next item is taken.
// When a step crosses into region 2, or a load has a zero radius, the
// region-2 start value is set up in SU1 to SU6, SU1 to SU5 on the same multiplier.
// While rsp_stall is high the current pixel holds and req_stall stays high
// until the fourth pixel of the step is taken.
// Synchronous reset returns the block to idle with no figure active and no
// pending pixels.
module midpoint_ellipse_raster
   import mer_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [COORD_BITS-1:0]        req_radius_x,
   input  logic [COORD_BITS-1:0]        req_radius_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic                         rsp_last_of_step,
   output logic                         rsp_figure_done
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer and pixel emission control.
   mer_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_figure_done  (rsp_figure_done),
      .cmd              (cmd),
      .status           (status)
   );

   // Step registers, shared multiplier and pixel adders.
   mer_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius_x (req_radius_x),
      .radius_y (req_radius_y),
      .status   (status),
      .pixel_x  (rsp_pixel_x),
      .pixel_y  (rsp_pixel_y)
   );

endmodule

// ----- tb/midpoint_ellipse_raster_test.sv -----
module midpoint_ellipse_raster_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = mer_pkg::COORD_BITS_DEF;
   localparam int PW = CW + 2;

   // Item kinds on the request channel.
   localparam bit KIND_LOAD = 1'b0;
   localparam bit KIND_STEP = 1'b1;

   // How a directed row is checked: typed-in pixels or the ellipse tracer.
   localparam bit CHK_MODEL = 1'b0;
   localparam bit CHK_TYPED = 1'b1;

   localparam int TARGET_ITEMS = 480;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 32;

   typedef enum logic [1:0] {
      FIG_IDLE    = 2'd0,
      FIG_REGION1 = 2'd1,
      FIG_REGION2 = 2'd2
   } fig_phase_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic [PW-1:0] px;
      logic [PW-1:0] py;
      logic          last;
      logic          done;
   } pixel_word_type;

   typedef struct packed {
      bit                   kind;
      logic [CW-1:0]        cx;
      logic [CW-1:0]        cy;
      logic [CW-1:0]        rx;
      logic [CW-1:0]        ry;
      bit                   check;
      bit                   has_pix;
      logic signed [PW-1:0] xp;
      logic signed [PW-1:0] xm;
      logic signed [PW-1:0] yp;
      logic signed [PW-1:0] ym;
      bit                   done;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_kind = 1'b0;
   logic [CW-1:0]        req_center_x = '0;
   logic [CW-1:0]        req_center_y = '0;
   logic [CW-1:0]        req_radius_x = '0;
   logic [CW-1:0]        req_radius_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [PW-1:0] rsp_pixel_x;
   logic signed [PW-1:0] rsp_pixel_y;
   logic                 rsp_last_of_step;
   logic                 rsp_figure_done;

   // Tracer state, kept at the widths of the block apart from the wider decision value.
   fig_phase_type        fig_phase = FIG_IDLE;
   logic [CW-1:0]        ctr_x = '0;
   logic [CW-1:0]        ctr_y = '0;
   logic [2*CW-1:0]      rx_sq = '0;
   logic [2*CW-1:0]      ry_sq = '0;
   logic signed [CW:0]   pos_x = '0;
   logic signed [CW:0]   pos_y = '0;
   logic signed [32:0]   gx = '0;
   logic signed [32:0]   gy = '0;
   logic signed [47:0]   dec = '0;

   pixel_word_type       pixel_queue[$];
   stim_row_type         script[24];

   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   words_sent = 0;
   int                   loads_sent = 0;
   int                   steps_sent = 0;
   int                   idle_steps = 0;
   int                   pixels_seen = 0;
   int                   figures_seen = 0;
   int                   burst_left = 0;
   int                   stall_left = 0;
   stall_mode_type       stall_mode = STALL_NONE;

   midpoint_ellipse_raster #(
      .COORD_BITS(CW)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius_x    (req_radius_x),
      .req_radius_y    (req_radius_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_last_of_step(rsp_last_of_step),
      .rsp_figure_done (rsp_figure_done)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels still expected", $time, pixel_queue.size());
         $display("midpoint_ellipse_raster regression: fail");
         $finish;
      end
   end

   // Append one expected pixel, wrapped to the output width.
   function automatic void queue_pixel(input longint px, input longint py,
                                       input bit last, input bit done);
      pixel_word_type w;
      w.px   = px[PW-1:0];
      w.py   = py[PW-1:0];
      w.last = last;
      w.done = done;
      pixel_queue = {pixel_queue, w};
   endfunction

   // Resolve the loop tests: enter region 2 with its exact start value, or finish.
   function automatic void ellipse_settle();
      longint xv, ym, a, s, rxs, rys;
      if (fig_phase == FIG_REGION1 && !(gx < gy)) begin
         xv  = longint'(pos_x);
         ym  = longint'(pos_y) - 1;
         rxs = longint'(rx_sq);
         rys = longint'(ry_sq);
         a   = rys * (xv * xv + xv) + rxs * (ym * ym) - rxs * rys;
         s   = a + rys / 4;
         // Truncation toward zero of the half-pixel term needs a correction here.
         if (s < 0 && (rys % 4) == 1) begin
            s += 1;
         end
         dec       = 48'(s);
         fig_phase = FIG_REGION2;
      end
      if (fig_phase == FIG_REGION2 && pos_y < 0) begin
         fig_phase = FIG_IDLE;
      end
   endfunction

   // Apply one accepted word to the tracer and, when asked, queue its pixels.
   function automatic void ellipse_accept(input bit kind, input logic [CW-1:0] cx_in,
                                          input logic [CW-1:0] cy_in,
                                          input logic [CW-1:0] rx_in,
                                          input logic [CW-1:0] ry_in, input bit emit);
      longint rxl, ryl, rxs, rys, ox, oy, lx, ly, lgx, lgy, ld, cxl, cyl;
      if (kind == KIND_LOAD) begin
         rxl       = longint'(rx_in);
         ryl       = longint'(ry_in);
         ctr_x     = cx_in;
         ctr_y     = cy_in;
         rx_sq     = (2*CW)'(rxl * rxl);
         ry_sq     = (2*CW)'(ryl * ryl);
         pos_x     = '0;
         pos_y     = (CW+1)'(ryl);
         dec       = 48'(ryl * ryl - rxl * rxl * ryl + (rxl * rxl) / 4);
         gx        = '0;
         gy        = 33'(2 * rxl * rxl * ryl);
         fig_phase = FIG_REGION1;
         ellipse_settle();
      end else if (fig_phase != FIG_IDLE) begin
         ox  = longint'(pos_x);
         oy  = longint'(pos_y);
         lx  = ox;
         ly  = oy;
         lgx = longint'(gx);
         lgy = longint'(gy);
         ld  = longint'(dec);
         rxs = longint'(rx_sq);
         rys = longint'(ry_sq);
         if (fig_phase == FIG_REGION1) begin
            lx  += 1;
            lgx += 2 * rys;
            if (ld < 0) begin
               ld += lgx + rys;
            end else begin
               ly  -= 1;
               lgy -= 2 * rxs;
               ld  += lgx - lgy + rys;
            end
         end else begin
            ly  -= 1;
            lgy -= 2 * rxs;
            if (ld > 0) begin
               ld += rxs - lgy;
            end else begin
               lx  += 1;
               lgx += 2 * rys;
               ld  += lgx - lgy + rxs;
            end
         end
         pos_x = (CW+1)'(lx);
         pos_y = (CW+1)'(ly);
         gx    = 33'(lgx);
         gy    = 33'(lgy);
         dec   = 48'(ld);
         ellipse_settle();
         if (emit) begin
            cxl = longint'(ctr_x);
            cyl = longint'(ctr_y);
            queue_pixel(cxl + ox, cyl + oy, 1'b0, 1'b0);
            queue_pixel(cxl - ox, cyl + oy, 1'b0, 1'b0);
            queue_pixel(cxl + ox, cyl - oy, 1'b0, 1'b0);
            queue_pixel(cxl - ox, cyl - oy, 1'b1, fig_phase == FIG_IDLE);
         end
      end
   endfunction

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 7);
      end
   endtask

   // Present one word, wait for it to be taken, then trace it.
   task automatic issue_word(input bit kind, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [CW-1:0] rx, input logic [CW-1:0] ry,
                             input bit emit);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_x <= rx;
      req_radius_y <= ry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (kind == KIND_LOAD) begin
         loads_sent++;
      end else begin
         steps_sent++;
         if (fig_phase == FIG_IDLE) begin
            idle_steps++;
         end
      end
      ellipse_accept(kind, cx, cy, rx, ry, emit);
      pace_sender();
   endtask

   // A step word with random don't-care payload.
   task automatic issue_step();
      issue_word(KIND_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                 1'b1);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Receiver: its own stall pattern, changing mode every so often.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 160);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         STALL_PATTERN: begin
            rsp_stall <= (stall_left % 5) < 2;
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // Compare every accepted pixel word with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      pixel_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen++;
         if (rsp_figure_done) begin
            figures_seen++;
         end
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel word, expected none, got (%0d,%0d)",
                     $time, rsp_pixel_x, rsp_pixel_y);
            error_count++;
         end else begin
            want = pixel_queue.pop_front();
            check_field("pixel_x", int'($signed(want.px)), int'(rsp_pixel_x));
            check_field("pixel_y", int'($signed(want.py)), int'(rsp_pixel_y));
            check_field("last_of_step", int'(want.last), int'(rsp_last_of_step));
            check_field("figure_done", int'(want.done), int'(rsp_figure_done));
         end
      end
   end

   initial begin : stimulus
      int size_class;
      int cap;
      int n;
      logic [CW-1:0] rad_x, rad_y;

      // Directed words; typed rows carry their four pixels as (+x,-x,+y,-y).
      script = '{
         // Step right after reset: nothing to draw.
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         // Point ellipse: one step of four identical pixels, then finished.
         '{KIND_LOAD, 5, 7, 0, 0, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 1, 5, 5, 7, 7, 1},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         // Largest centre and radii: top and bottom points of the first step.
         '{KIND_LOAD, 1023, 1023, 1023, 1023, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 1, 1023, 1023, 2046, 0, 0},
         // Load while drawing, with the bottom pixel going negative.
         '{KIND_LOAD, 0, 0, 1023, 1023, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 1, 0, 0, 1023, -1023, 0},
         '{KIND_STEP, 1023, 1023, 1023, 1023, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         // Zero horizontal radius starts straight in region 2.
         '{KIND_LOAD, 0, 0, 0, 1023, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         // Zero vertical radius: one step on the centre row.
         '{KIND_LOAD, 1023, 0, 1023, 0, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 1, 1023, 1023, 0, 0, 1},
         // Thin vertical line drawn to the end, then a step on an idle block.
         '{KIND_LOAD, 512, 512, 0, 3, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_TYPED, 0, 0, 0, 0, 0, 0},
         // Unit circle, crossing into region 2 on a step.
         '{KIND_LOAD, 682, 341, 1, 1, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0},
         '{KIND_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0, 0, 0, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (script[i]) begin
         if (script[i].check == CHK_TYPED && script[i].has_pix) begin
            queue_pixel(longint'(script[i].xp), longint'(script[i].yp), 1'b0, 1'b0);
            queue_pixel(longint'(script[i].xm), longint'(script[i].yp), 1'b0, 1'b0);
            queue_pixel(longint'(script[i].xp), longint'(script[i].ym), 1'b0, 1'b0);
            queue_pixel(longint'(script[i].xm), longint'(script[i].ym), 1'b1,
                        script[i].done);
         end
         issue_word(script[i].kind, script[i].cx, script[i].cy, script[i].rx, script[i].ry,
                    script[i].check == CHK_MODEL);
      end

      // Random figures: mostly small and drawn to the end, some abandoned early.
      while (words_sent - idle_steps < TARGET_ITEMS) begin
         if (fig_phase == FIG_IDLE && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) issue_step();
         end
         size_class = $urandom_range(0, 19);
         if (size_class < 14) begin
            rad_x = CW'($urandom_range(0, 12));
            rad_y = CW'($urandom_range(0, 12));
            cap   = ($urandom_range(0, 6) != 0) ? 4096 : $urandom_range(0, 10);
         end else if (size_class < 18) begin
            rad_x = CW'($urandom_range(0, 63));
            rad_y = CW'($urandom_range(0, 63));
            cap   = ($urandom_range(0, 6) != 0) ? 4096 : $urandom_range(0, 10);
         end else begin
            rad_x = CW'($urandom);
            rad_y = CW'($urandom);
            cap   = $urandom_range(1, 60);
         end
         issue_word(KIND_LOAD, CW'($urandom), CW'($urandom), rad_x, rad_y, 1'b1);
         n = 0;
         while (fig_phase != FIG_IDLE && n < cap) begin
            issue_step();
            n++;
         end
      end

      // Drain, then allow for any stray pixels.
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d words: %0d loads, %0d steps (%0d on an idle block).",
               words_sent, loads_sent, steps_sent, idle_steps);
      $display("Checked %0d pixel words across %0d finished figures, %0d mismatches.",
               pixels_seen, figures_seen, error_count);
      if (error_count == 0) begin
         $display("midpoint_ellipse_raster regression: pass");
      end else begin
         $display("midpoint_ellipse_raster regression: fail");
      end
      $finish;
   end

endmodule
